@@ rtl/pwmbcd_pkg.sv @@
package pwmbcd_pkg;

   localparam int unsigned NUM_DIGITS = 4;
   localparam int unsigned DIGIT_W    = $clog2(NUM_DIGITS);
   localparam int unsigned ENABLE_W   = 4;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned TICK_W     = 16;

   // register indexes, taken from address bit 2
   localparam logic REG_ON_TICKS    = 1'b0;
   localparam logic REG_BLANK_TICKS = 1'b1;

   localparam logic [TICK_W-1:0] ON_TICKS_RESET    = 16'd5000;
   localparam logic [TICK_W-1:0] BLANK_TICKS_RESET = 16'd50;

   localparam logic [7:0]          ENABLE_PATTERN = 8'b1111_0111;
   localparam logic [ENABLE_W-1:0] ENABLE_ALL_OFF = 4'h F;

   typedef logic [3:0] bcd_type;
   typedef logic [6:0] seg_type;

   typedef struct packed {
      bcd_type hundreds;
      bcd_type tens;
      bcd_type units;
   } bcd_split_type;

   function automatic seg_type seg_decode(input bcd_type code);
      seg_type segs;
      case (code)
         4'd0:    segs = 7'h3f;
         4'd1:    segs = 7'h06;
         4'd2:    segs = 7'h5b;
         4'd3:    segs = 7'h4f;
         4'd4:    segs = 7'h66;
         4'd5:    segs = 7'h6d;
         4'd6:    segs = 7'h7d;
         4'd7:    segs = 7'h07;
         4'd8:    segs = 7'h7f;
         4'd9:    segs = 7'h6f;
         default: segs = 7'h00;
      endcase
      return segs;
   endfunction

   // active-low enable; only the first four digits have a line
   function automatic logic [ENABLE_W-1:0] digit_enable(input logic [DIGIT_W-1:0] d);
      logic [7:0] shifted;
      logic [ENABLE_W-1:0] en;
      shifted = ENABLE_PATTERN >> d;
      if (32'(d) < ENABLE_W) begin
         en = shifted[ENABLE_W-1:0];
      end else begin
         en = ENABLE_ALL_OFF;
      end
      return en;
   endfunction

   // 8-bit binary to three BCD digits; tens by reciprocal (205 / 2048)
   function automatic bcd_split_type bcd_split(input logic [7:0] v);
      bcd_split_type res;
      logic [7:0]  rem8;
      logic [6:0]  rem;
      logic [14:0] prod;
      logic [6:0]  tens_x10;
      logic [6:0]  units;
      if (v >= 8'd200) begin
         res.hundreds = 4'd2;
         rem8 = v - 8'd200;
      end else if (v >= 8'd100) begin
         res.hundreds = 4'd1;
         rem8 = v - 8'd100;
      end else begin
         res.hundreds = 4'd0;
         rem8 = v;
      end
      rem = rem8[6:0];
      prod = 15'(rem) * 15'd205;
      res.tens = prod[14:11];
      tens_x10 = 7'(res.tens) * 7'd10;
      units = rem - tens_x10;
      res.units = units[3:0];
      return res;
   endfunction

endpackage

@@ rtl/pulse_width_meter_bcd_display_top.sv @@
// Each response beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one beat per cycle unless the response stalls; the tick update is one registered pass.
// A stalled response holds in the output register; req_ready is high when it is empty or rsp_ready is high.
// Reset (synchronous, active high) clears the meter, digits and scanner and
// loads on_ticks = 5000, blank_ticks = 50.
module pulse_width_meter_bcd_display_top (
   input  logic                                clock,
   input  logic                                reset,
   // tick input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_pulse_level,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_measured_value,
   output logic [6:0]                          rsp_segments,
   output logic [pwmbcd_pkg::ENABLE_W-1:0]     rsp_digit_enable_n,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pwmbcd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pwmbcd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pwmbcd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready
);
   import pwmbcd_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [TICK_W-1:0] on_ticks_ff, blank_ticks_ff;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ticks_ff    <= ON_TICKS_RESET;
         blank_ticks_ff <= BLANK_TICKS_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_ON_TICKS:    on_ticks_ff    <= pwdata[TICK_W-1:0];
            REG_BLANK_TICKS: blank_ticks_ff <= pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ON_TICKS:    prdata = CSR_DATA_W'(on_ticks_ff);
         REG_BLANK_TICKS: prdata = CSR_DATA_W'(blank_ticks_ff);
         default:         prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake: advance state only on an accepted beat
   // ------------------------------------------------------------------
   logic req_accept;
   logic rsp_valid_ff;

   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign req_accept = req_valid & req_ready;
   assign rsp_valid  = rsp_valid_ff;

   // ------------------------------------------------------------------
   // Pulse measurement
   // ------------------------------------------------------------------
   logic          previous_level_ff, previous_level_in;
   logic          measuring_ff, measuring_in;
   logic [7:0]    pulse_count_ff, pulse_count_in;
   logic [7:0]    latched_value_ff, latched_value_in;
   bcd_type       digit_store_ff [NUM_DIGITS];
   bcd_type       digit_store_in [NUM_DIGITS];
   logic [7:0]    count_inc;
   bcd_split_type split;

   assign count_inc = pulse_count_ff + 8'd1;
   assign split     = bcd_split(count_inc);

   always_comb begin
      measuring_in      = measuring_ff;
      pulse_count_in    = pulse_count_ff;
      latched_value_in  = latched_value_ff;
      digit_store_in    = digit_store_ff;
      previous_level_in = req_pulse_level;
      if (!measuring_ff) begin
         // start on a rising edge
         if (req_pulse_level && !previous_level_ff) begin
            measuring_in   = 1'b1;
            pulse_count_in = '0;
         end
      end else begin
         // a rising edge while counting just counts
         pulse_count_in = count_inc;
         if (!req_pulse_level && previous_level_ff) begin
            latched_value_in  = count_inc;
            digit_store_in[1] = split.hundreds;
            digit_store_in[2] = split.tens;
            digit_store_in[3] = split.units;
            pulse_count_in    = '0;
            measuring_in      = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Display scanner
   // ------------------------------------------------------------------
   logic [DIGIT_W-1:0] scan_digit_ff, scan_digit_in;
   logic               scan_blanking_ff, scan_blanking_in;
   logic [TICK_W-1:0]  phase_timer_ff, phase_timer_in;
   logic [TICK_W:0]    elapsed;
   logic [TICK_W-1:0]  on_limit;
   logic [DIGIT_W-1:0] digit_next;
   seg_type            segs;
   logic [ENABLE_W-1:0] enable_n;

   assign elapsed    = {1'b0, phase_timer_ff} + 17'd1;
   // a zero on time acts as one tick
   assign on_limit   = (on_ticks_ff == '0) ? TICK_W'(1) : on_ticks_ff;
   assign digit_next = (scan_digit_ff == DIGIT_W'(NUM_DIGITS - 1)) ?
                       '0 : scan_digit_ff + DIGIT_W'(1);

   // outputs show the phase at the start of the tick, digits after update
   always_comb begin
      if (scan_blanking_ff) begin
         segs     = '0;
         enable_n = ENABLE_ALL_OFF;
      end else begin
         segs     = seg_decode(digit_store_in[scan_digit_ff]);
         enable_n = digit_enable(scan_digit_ff);
      end
   end

   always_comb begin
      scan_digit_in    = scan_digit_ff;
      scan_blanking_in = scan_blanking_ff;
      phase_timer_in   = elapsed[TICK_W-1:0];
      if (!scan_blanking_ff) begin
         if (elapsed >= {1'b0, on_limit}) begin
            phase_timer_in = '0;
            if (blank_ticks_ff == '0) begin
               // no dark phase: light the next digit at once
               scan_digit_in = digit_next;
            end else begin
               scan_blanking_in = 1'b1;
            end
         end
      end else if (elapsed >= {1'b0, blank_ticks_ff}) begin
         scan_digit_in    = digit_next;
         scan_blanking_in = 1'b0;
         phase_timer_in   = '0;
      end
   end

   // ------------------------------------------------------------------
   // State and result registers
   // ------------------------------------------------------------------
   logic [7:0]          rsp_measured_value_ff;
   seg_type             rsp_segments_ff;
   logic [ENABLE_W-1:0] rsp_digit_enable_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_level_ff <= 1'b0;
         measuring_ff      <= 1'b0;
         pulse_count_ff    <= '0;
         latched_value_ff  <= '0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_store_ff[i] <= '0;
         end
         scan_digit_ff     <= '0;
         scan_blanking_ff  <= 1'b0;
         phase_timer_ff    <= '0;
      end else if (req_accept) begin
         previous_level_ff <= previous_level_in;
         measuring_ff      <= measuring_in;
         pulse_count_ff    <= pulse_count_in;
         latched_value_ff  <= latched_value_in;
         digit_store_ff    <= digit_store_in;
         scan_digit_ff     <= scan_digit_in;
         scan_blanking_ff  <= scan_blanking_in;
         phase_timer_ff    <= phase_timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_measured_value_ff <= latched_value_in;
         rsp_segments_ff       <= segs;
         rsp_digit_enable_n_ff <= enable_n;
      end
   end

   assign rsp_measured_value = rsp_measured_value_ff;
   assign rsp_segments       = rsp_segments_ff;
   assign rsp_digit_enable_n = rsp_digit_enable_n_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_one_digit_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(~rsp_digit_enable_n) <= 1)
      else $error("more than one digit enabled");

   a_dark_when_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_digit_enable_n == ENABLE_ALL_OFF) |-> rsp_segments == '0
      || scan_digit_ff != '0 || NUM_DIGITS > ENABLE_W)
      else $error("segments driven with no digit enabled");

   a_bcd_range: assert property (@(posedge clock) disable iff (reset)
      digit_store_ff[0] == '0 && digit_store_ff[1] <= 4'd2
      && digit_store_ff[2] <= 4'd9 && digit_store_ff[3] <= 4'd9)
      else $error("digit store out of range");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(pulse_count_ff) && $stable(phase_timer_ff))
      else $error("state moved without an accepted beat");

   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !measuring_ff |-> pulse_count_ff == '0)
      else $error("counter not cleared while idle");

endmodule
